@@ src/iscm_pkg.sv @@
// Shared constants, register indexes and sequencer state type for the
// impact step cadence meter. No dependencies.
`timescale 1ns / 1ps
package iscm_pkg;

   localparam int RING_DEPTH = 16;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);
   localparam int SPM_SCALE  = 60000;
   localparam int NUM_W      = $clog2((RING_DEPTH - 1) * SPM_SCALE + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [10:0] CADENCE_MAX   = 11'd2047;
   localparam logic [31:0] BASELINE_INIT = 32'd1000 << 16;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STALE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE    = 3'd6;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_SQ    = 11'b000_0000_0010,
      ST_ROOT  = 11'b000_0000_0100,
      ST_BMUL  = 11'b000_0000_1000,
      ST_BUPD  = 11'b000_0001_0000,
      ST_SADDR = 11'b000_0010_0000,
      ST_SDATA = 11'b000_0100_0000,
      ST_EVAL  = 11'b000_1000_0000,
      ST_NMUL  = 11'b001_0000_0000,
      ST_DIV   = 11'b010_0000_0000,
      ST_FIN   = 11'b100_0000_0000
   } state_type;

endpackage

@@ src/iscm_if.sv @@
// Channel interfaces for the cadence meter: sample input, result output and
// register write port. Depends on iscm_pkg.
`timescale 1ns / 1ps
interface iscm_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [14:0] accel_x;
   logic signed [14:0] accel_y;
   logic signed [14:0] accel_z;
   logic [31:0]        time_ms;
   modport source (output valid, cmd, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink   (input valid, cmd, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface iscm_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cadence_spm;
   logic [31:0] step_total;
   logic        step_found;
   logic        impact_active;
   modport source (output valid, cadence_spm, step_total, step_found, impact_active,
                   input ready);
   modport sink   (input valid, cadence_spm, step_total, step_found, impact_active,
                   output ready);
endinterface

interface iscm_csr_if
   import iscm_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ src/iscm_isqrt.sv @@
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module iscm_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] operand,
   output logic        done,
   output logic [15:0] root
);
   logic [31:0] rad_ff, rad_in;
   logic [18:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [18:0] rem_next, trial;

   always_comb begin
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_next = {rem_ff[16:0], rad_ff[31:30]};
      trial    = {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in  = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[29:0], 2'b00};
         if (rem_next >= trial) begin
            rem_in  = rem_next - trial;
            root_in = {root_ff[14:0], 1'b1};
         end else begin
            rem_in  = rem_next;
            root_in = {root_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

@@ src/iscm_div.sv @@
// Restoring divider for the step rate, one quotient bit per cycle.
// Depends on iscm_pkg for the numerator width.
`timescale 1ns / 1ps
module iscm_div
   import iscm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [15:0]      denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [15:0]      den_ff, den_in;
   logic [16:0]      rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [16:0]      rem_next;

   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_next = {rem_ff[15:0], num_ff[NUM_W-1]};
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The quotient bits shift in behind the numerator bits.
         if (rem_next >= {1'b0, den_ff}) begin
            rem_in = rem_next - {1'b0, den_ff};
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_next;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule

@@ src/impact_step_cadence_meter.sv @@
// Impact step cadence meter: one sample in, one result beat out, driven by a
// sequencer around a shared multiplier, a square root unit and a divider.
// Depends on iscm_pkg, iscm_if, iscm_isqrt and iscm_div.
`timescale 1ns / 1ps
// A sample passes the squaring, root, baseline and ring-scan states, plus the
// rate multiply and divide when a cadence is computed, before its result beat;
// the block is idle again before the next beat is taken. The scan of the
// 16-entry ring (an address and a data state per entry via its single read
// port) and the bit-serial root and divide set the latency. A clear beat goes
// from idle to the finish state. The block takes one beat at a time; a
// finished result waits in the output register as the next sample is taken.
module impact_step_cadence_meter
   import iscm_pkg::*;
(
   input logic clock,
   input logic reset,
   iscm_req_if.sink   req_bus,
   iscm_rsp_if.source rsp_bus,
   iscm_csr_if.sink   csr_bus
);
   state_type state_ff, state_in;

   logic [8:0]  thr_ff;
   logic [7:0]  rel_ff;
   logic [15:0] alpha_ff;
   logic [10:0] min_step_ff;
   logic [15:0] window_ff;
   logic [14:0] stale_ff;
   logic [7:0]  settle_cfg_ff;

   logic signed [14:0] x_ff, y_ff, z_ff;
   logic [31:0] now_ff;
   logic [29:0] acc_ff;
   logic [1:0]  sq_cnt_ff;
   logic [14:0] m_ff;
   logic signed [50:0] prod_ff;

   logic [31:0] base_ff;
   logic        above_ff, primed_ff, found_ff;
   logic [7:0]  settle_ff;
   logic [31:0] last_ff, total_ff;
   logic [RING_AW-1:0] head_ff;
   logic [FILL_W-1:0]  fill_ff, idx_ff, n_ff;
   logic [15:0] old_ff, new_ff, span_ff;
   logic [10:0] cad_ff;
   logic [31:0] rd_ff;
   logic [31:0] ring_mem [RING_DEPTH];

   logic        rsp_valid_ff;
   logic [10:0] rsp_cad_ff;
   logic [31:0] rsp_total_ff;
   logic        rsp_found_ff, rsp_above_ff;

   logic req_acc, rsp_free;
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mul_p;

   logic        sq_start, sq_done;
   logic [15:0] sq_root;
   logic        dv_start, dv_done;
   logic [NUM_W-1:0] dv_quot;

   logic [31:0] mq, base_new, age, gap;
   logic signed [33:0] diff, dv;
   logic [32:0] dev;
   logic [24:0] thr_q, rel_q;
   logic [8:0]  settle_inc;
   logic        take_step;
   logic [NUM_W+1:0] cad_sum;

   assign req_acc  = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   // Shared multiplier: squares, baseline step and step-count scaling.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ: begin
            case (sq_cnt_ff)
               2'd0:    begin mul_a = 34'(x_ff); mul_b = 17'(x_ff); end
               2'd1:    begin mul_a = 34'(y_ff); mul_b = 17'(y_ff); end
               default: begin mul_a = 34'(z_ff); mul_b = 17'(z_ff); end
            endcase
         end
         ST_BMUL: begin
            mul_a = diff;
            mul_b = $signed({1'b0, alpha_ff});
         end
         ST_NMUL: begin
            mul_a = $signed({{(34-FILL_W){1'b0}}, n_ff - FILL_W'(1)});
            mul_b = 17'(SPM_SCALE);
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   assign sq_start = (state_ff == ST_SQ) && (sq_cnt_ff == 2'd2);
   assign dv_start = (state_ff == ST_NMUL);

   iscm_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand ({2'b00, acc_ff + mul_p[29:0]}),
      .done    (sq_done),
      .root    (sq_root)
   );

   iscm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (mul_p[NUM_W-1:0]),
      .denom (span_ff),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   always_comb begin
      mq         = {1'b0, m_ff, 16'h0000};
      diff       = $signed({2'b00, mq}) - $signed({2'b00, base_ff});
      // Arithmetic shift gives the floor toward minus infinity.
      base_new   = base_ff + 32'(prod_ff >>> 16);
      dv         = $signed({2'b00, mq}) - $signed({2'b00, base_new});
      dev        = dv[33] ? 33'(-dv) : 33'(dv);
      thr_q      = {thr_ff, 16'h0000};
      rel_q      = {17'(thr_ff) * 17'(rel_ff), 8'h00};
      settle_inc = {1'b0, settle_ff} + 9'd1;
      gap        = now_ff - last_ff;
      take_step  = primed_ff && !above_ff && (dev > {8'h00, thr_q})
                   && (gap >= {21'h0, min_step_ff});
      age        = now_ff - rd_ff;
      cad_sum    = (NUM_W+2)'(cad_ff) + (NUM_W+2)'(dv_quot)
                   + {dv_quot, 1'b0};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc) state_in = (req_bus.cmd == CMD_CLEAR) ? ST_FIN : ST_SQ;
         ST_SQ:    if (sq_cnt_ff == 2'd2) state_in = ST_ROOT;
         ST_ROOT:  if (sq_done) state_in = ST_BMUL;
         ST_BMUL:  state_in = ST_BUPD;
         ST_BUPD:  state_in = ST_SADDR;
         ST_SADDR: state_in = (idx_ff == fill_ff) ? ST_EVAL : ST_SDATA;
         ST_SDATA: state_in = ST_SADDR;
         ST_EVAL: begin
            if (n_ff >= FILL_W'(2) && new_ff < 16'(stale_ff) && old_ff != new_ff)
               state_in = ST_NMUL;
            else
               state_in = ST_FIN;
         end
         ST_NMUL:  state_in = ST_DIV;
         ST_DIV:   if (dv_done) state_in = ST_FIN;
         ST_FIN:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= 9'd180;
         rel_ff        <= 8'd141;
         alpha_ff      <= 16'd655;
         min_step_ff   <= 11'd200;
         window_ff     <= 16'd10000;
         stale_ff      <= 15'd3000;
         settle_cfg_ff <= 8'd25;
         base_ff       <= BASELINE_INIT;
         above_ff      <= 1'b0;
         primed_ff     <= 1'b0;
         found_ff      <= 1'b0;
         settle_ff     <= '0;
         last_ff       <= '0;
         total_ff      <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
         cad_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         sq_cnt_ff     <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.reg_index)
               REG_THRESHOLD: thr_ff        <= csr_bus.wdata[8:0];
               REG_RELEASE:   rel_ff        <= csr_bus.wdata[7:0];
               REG_ALPHA:     alpha_ff      <= csr_bus.wdata;
               REG_MIN_STEP:  min_step_ff   <= csr_bus.wdata[10:0];
               REG_WINDOW:    window_ff     <= csr_bus.wdata;
               REG_STALE:     stale_ff      <= csr_bus.wdata[14:0];
               REG_SETTLE:    settle_cfg_ff <= csr_bus.wdata[7:0];
               default: ;
            endcase
         end
         if (state_ff == ST_FIN && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_bus.ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               found_ff  <= 1'b0;
               sq_cnt_ff <= '0;
               if (req_acc && req_bus.cmd == CMD_CLEAR) begin
                  base_ff   <= BASELINE_INIT;
                  above_ff  <= 1'b0;
                  primed_ff <= 1'b0;
                  settle_ff <= '0;
                  last_ff   <= '0;
                  total_ff  <= '0;
                  head_ff   <= '0;
                  fill_ff   <= '0;
                  cad_ff    <= '0;
               end
            end
            ST_SQ:   sq_cnt_ff <= sq_cnt_ff + 2'd1;
            ST_BUPD: begin
               base_ff <= base_new;
               idx_ff  <= '0;
               n_ff    <= '0;
               if (!primed_ff) begin
                  if (settle_inc > {1'b0, settle_cfg_ff}) begin
                     primed_ff <= 1'b1;
                     settle_ff <= '0;
                  end else begin
                     settle_ff <= settle_inc[7:0];
                  end
               end else if (!above_ff && dev > {8'h00, thr_q}) begin
                  above_ff <= 1'b1;
                  if (take_step) begin
                     last_ff  <= now_ff;
                     head_ff  <= (head_ff == RING_AW'(RING_DEPTH - 1)) ? '0
                                 : head_ff + 1'b1;
                     if (fill_ff != FILL_W'(RING_DEPTH)) fill_ff <= fill_ff + 1'b1;
                     total_ff <= total_ff + 32'd1;
                     found_ff <= 1'b1;
                  end
               end else if (above_ff && dev < {8'h00, rel_q}) begin
                  above_ff <= 1'b0;
               end
            end
            ST_SDATA: begin
               idx_ff <= idx_ff + 1'b1;
               if (age <= {16'h0000, window_ff}) begin
                  n_ff <= n_ff + 1'b1;
                  if (n_ff == '0 || age[15:0] > old_ff) old_ff <= age[15:0];
                  if (n_ff == '0 || age[15:0] < new_ff) new_ff <= age[15:0];
               end
            end
            ST_EVAL: begin
               span_ff <= old_ff - new_ff;
               if (!(n_ff >= FILL_W'(2) && new_ff < 16'(stale_ff))
                   && gap >= {17'h0, stale_ff})
                  cad_ff <= '0;
            end
            ST_DIV: begin
               if (dv_done)
                  cad_ff <= (cad_sum[NUM_W+1:2] > (NUM_W)'(CADENCE_MAX)) ? CADENCE_MAX
                            : cad_sum[12:2];
            end
            default: ;
         endcase
      end
   end

   // Payload registers and the step ring.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff   <= req_bus.accel_x;
         y_ff   <= req_bus.accel_y;
         z_ff   <= req_bus.accel_z;
         now_ff <= req_bus.time_ms;
         acc_ff <= '0;
      end else if (state_ff == ST_SQ) begin
         acc_ff <= acc_ff + mul_p[29:0];
      end
      if (state_ff == ST_ROOT && sq_done) m_ff <= sq_root[14:0];
      if (state_ff == ST_BMUL) prod_ff <= mul_p;
      if (state_ff == ST_BUPD && take_step) ring_mem[head_ff] <= now_ff;
      if (state_ff == ST_SADDR) rd_ff <= ring_mem[idx_ff[RING_AW-1:0]];
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_cad_ff   <= cad_ff;
         rsp_total_ff <= total_ff;
         rsp_found_ff <= found_ff;
         rsp_above_ff <= above_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cadence_spm   = rsp_cad_ff;
   assign rsp_bus.step_total    = rsp_total_ff;
   assign rsp_bus.step_found    = rsp_found_ff;
   assign rsp_bus.impact_active = rsp_above_ff;
endmodule

@@ sim/impact_step_cadence_meter_tb.sv @@
// Self-checking testbench for the impact step cadence meter: random and directed
// sample beats, a beat-level predictor of cadence and step state, and random stalls.
// Depends on iscm_pkg, iscm_if and the impact_step_cadence_meter RTL.
`timescale 1ns / 1ps
import iscm_pkg::*;

typedef struct packed {
   logic [10:0] cadence;
   logic [31:0] steps;
   logic        found;
   logic        active;
} meter_result_type;

class cadence_scoreboard;
   int unsigned thr_mg, rel_q8, alpha, min_gap, win_ms, stale_lim, settle_n;
   logic [31:0] base_q16;
   bit          above, primed;
   int unsigned settle_cnt;
   logic [31:0] last_step;
   logic [31:0] stamps [RING_DEPTH];
   int unsigned head, fill;
   logic [10:0] cad;
   logic [31:0] step_cnt;
   meter_result_type pending[$];
   int errors;
   int steps_seen, nonzero_cad;

   function new();
      thr_mg = 180; rel_q8 = 141; alpha = 655; min_gap = 200;
      win_ms = 10000; stale_lim = 3000; settle_n = 25;
      errors = 0; steps_seen = 0; nonzero_cad = 0;
      clear_session();
   endfunction

   function void clear_session();
      base_q16 = BASELINE_INIT;
      above = 0; primed = 0; settle_cnt = 0; last_step = 0;
      foreach (stamps[i]) stamps[i] = 0;
      head = 0; fill = 0; cad = 0; step_cnt = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
         REG_THRESHOLD: thr_mg    = v[8:0];
         REG_RELEASE:   rel_q8    = v[7:0];
         REG_ALPHA:     alpha     = v;
         REG_MIN_STEP:  min_gap   = v[10:0];
         REG_WINDOW:    win_ms    = v;
         REG_STALE:     stale_lim = v[14:0];
         REG_SETTLE:    settle_n  = v[7:0];
         default: ;
      endcase
   endfunction

   static function int unsigned root_floor(longint unsigned v);
      longint unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function void note_sample(logic cmd, logic signed [14:0] ax, logic signed [14:0] ay,
                             logic signed [14:0] az, logic [31:0] now);
      meter_result_type res;
      longint sq, mq, diff, prod, delta, dv;
      longint unsigned dev, thr, rel;
      int unsigned mag, n, oldest, newest, age, span;
      longint unsigned spm, c;
      res = '0;
      if (cmd == CMD_CLEAR) begin
         clear_session();
      end else begin
         sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
         mag = root_floor(sq);
         mq = longint'(mag) << 16;
         diff = mq - longint'(base_q16);
         prod = diff * longint'(alpha);
         delta = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
         base_q16 = 32'(longint'(base_q16) + delta);
         dv = mq - longint'(base_q16);
         dev = (dv < 0) ? -dv : dv;
         thr = longint'(thr_mg) << 16;
         rel = (longint'(thr_mg) * rel_q8) << 8;
         if (!primed) begin
            if (settle_cnt + 1 > settle_n) begin
               primed = 1; settle_cnt = 0;
            end else settle_cnt = (settle_cnt + 1) & 8'hff;
         end else if (!above && dev > thr) begin
            above = 1;
            if (32'(now - last_step) >= min_gap) begin
               last_step = now;
               stamps[head] = now;
               head = (head + 1 >= RING_DEPTH) ? 0 : head + 1;
               if (fill < RING_DEPTH) fill++;
               step_cnt++;
               res.found = 1;
               steps_seen++;
            end
         end else if (above && dev < rel) begin
            above = 0;
         end
         n = 0; oldest = 0; newest = 0;
         for (int i = 0; i < fill; i++) begin
            age = 32'(now - stamps[i]);
            if (age <= win_ms) begin
               if (n == 0 || age > oldest) oldest = age;
               if (n == 0 || age < newest) newest = age;
               n++;
            end
         end
         if (n >= 2 && newest < stale_lim) begin
            span = oldest - newest;
            if (span > 0) begin
               spm = (longint'(n - 1) * SPM_SCALE) / span;
               c = (cad + 3 * spm) / 4;
               cad = (c > CADENCE_MAX) ? CADENCE_MAX : c[10:0];
            end
         end else if (32'(now - last_step) >= stale_lim) begin
            cad = 0;
         end
      end
      res.cadence = cad;
      res.steps = step_cnt;
      res.active = above;
      if (cad != 0) nonzero_cad++;
      pending.push_back(res);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 30) $display("mismatch %s: got %0d, expected %0d", what, got, want);
   endtask

   task check_result(meter_result_type got);
      meter_result_type want;
      if (pending.size() == 0) begin
         report("result beat with nothing expected", 1, 0);
      end else begin
         want = pending.pop_front();
         if (got.cadence !== want.cadence) report("cadence_spm", got.cadence, want.cadence);
         if (got.steps !== want.steps) report("step_total", got.steps, want.steps);
         if (got.found !== want.found) report("step_found", got.found, want.found);
         if (got.active !== want.active) report("impact_active", got.active, want.active);
      end
   endtask
endclass

module impact_step_cadence_meter_tb
   import iscm_pkg::*;
;
   logic clock = 0;
   logic reset = 1;
   iscm_req_if req_bus();
   iscm_rsp_if rsp_bus();
   iscm_csr_if csr_bus();

   impact_step_cadence_meter dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   cadence_scoreboard board = new();
   int unsigned cycle_count = 0;
   int unsigned hold_off = 0;
   bit hold_req = 0;
   bit long_hold_done = 0;
   logic [31:0] clock_ms = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("impact_step_cadence_meter regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, mostly short, plus one long hold-off on request.
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready && !reset)
         board.check_result({rsp_bus.cadence_spm, rsp_bus.step_total,
                             rsp_bus.step_found, rsp_bus.impact_active});
      if (reset) begin
         rsp_bus.ready <= 0;
      end else if (hold_req && !long_hold_done) begin
         hold_off <= 400;
         long_hold_done <= 1;
         rsp_bus.ready <= 0;
      end else if (hold_off != 0) begin
         hold_off <= hold_off - 1;
         rsp_bus.ready <= 0;
      end else begin
         case ($urandom_range(0, 9))
            0: rsp_bus.ready <= 0;
            1: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= 1;
         endcase
      end
   end

   // Valid stays up into a following beat that has no gap; drain drops it.
   task send_beat(logic cmd, logic signed [14:0] ax, logic signed [14:0] ay,
                  logic signed [14:0] az, logic [31:0] t);
      int gap;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1; req_bus.cmd <= cmd;
      req_bus.accel_x <= ax; req_bus.accel_y <= ay; req_bus.accel_z <= az;
      req_bus.time_ms <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_sample(cmd, ax, ay, az, t);
   endtask

   task drain();
      req_bus.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      csr_bus.valid <= 1; csr_bus.reg_index <= idx; csr_bus.wdata <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.write_reg(idx, v);
      csr_bus.valid <= 0;
      @(posedge clock);
   endtask

   // A walking stride: quiet 1 g samples with periodic sharp impacts.
   task stride_run(int count, int unsigned dt, int unsigned period);
      logic signed [14:0] z;
      int unsigned ph;
      ph = 0;
      for (int i = 0; i < count; i++) begin
         clock_ms = clock_ms + dt + $urandom_range(0, 3);
         if (ph == 0) z = 15'(1000 + $urandom_range(300, 4000));
         else z = 15'(1000 + $urandom_range(0, 40) - 20);
         ph = (ph + 1 >= period) ? 0 : ph + 1;
         send_beat(CMD_SAMPLE, 15'($urandom_range(0, 60) - 30), 15'($urandom_range(0, 60) - 30),
                   z, clock_ms);
      end
   endtask

   task random_beat();
      logic [31:0] t;
      t = ($urandom_range(0, 30) == 0) ? $urandom : clock_ms + $urandom_range(0, 400);
      clock_ms = t;
      send_beat(($urandom_range(0, 40) == 0) ? CMD_CLEAR : CMD_SAMPLE,
                15'($urandom), 15'($urandom), 15'($urandom), t);
   endtask

   initial begin
      req_bus.valid = 0; req_bus.cmd = CMD_SAMPLE;
      req_bus.accel_x = 0; req_bus.accel_y = 0; req_bus.accel_z = 0; req_bus.time_ms = 0;
      csr_bus.valid = 0; csr_bus.reg_index = REG_THRESHOLD; csr_bus.wdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // Directed: field extremes, clear, and settling at zero.
      write_reg(REG_SETTLE, 0);
      send_beat(CMD_SAMPLE, 15'h4000, 15'h4000, 15'h4000, 32'hffff_fff0);
      send_beat(CMD_SAMPLE, 15'h3fff, 15'h3fff, 15'h3fff, 32'hffff_ffff);
      send_beat(CMD_SAMPLE, 0, 0, 0, 32'd5);
      send_beat(CMD_SAMPLE, 15'h4000, 0, 0, 32'd400);
      send_beat(CMD_SAMPLE, 0, 0, 15'd1000, 32'd600);
      send_beat(CMD_SAMPLE, 0, 0, 15'd3000, 32'd900);
      send_beat(CMD_SAMPLE, 0, 0, 15'd1000, 32'd1000);
      send_beat(CMD_SAMPLE, 0, 0, 15'd3000, 32'd1300);
      send_beat(CMD_SAMPLE, 0, 0, 15'd1000, 32'd1400);
      send_beat(CMD_SAMPLE, 0, 0, 15'd3000, 32'd1700);
      send_beat(CMD_SAMPLE, 0, 0, 15'd3000, 32'd1200);
      send_beat(CMD_CLEAR, 15'h7fff, 15'h7fff, 15'h7fff, 32'hffff_ffff);
      send_beat(CMD_SAMPLE, 0, 0, 15'd1000, 32'd0);
      drain();

      // Extremes: release 0 never releases, alpha 0 freezes baseline, stale 0.
      write_reg(REG_RELEASE, 0);
      write_reg(REG_ALPHA, 0);
      write_reg(REG_STALE, 0);
      write_reg(REG_THRESHOLD, 9'h1ff);
      write_reg(REG_MIN_STEP, 11'h7ff);
      write_reg(REG_WINDOW, 16'hffff);
      clock_ms = 10;
      stride_run(30, 100, 4);
      drain();

      write_reg(REG_RELEASE, 255);
      write_reg(REG_ALPHA, 16'hffff);
      write_reg(REG_STALE, 15'h7fff);
      write_reg(REG_THRESHOLD, 60);
      write_reg(REG_MIN_STEP, 50);
      write_reg(REG_WINDOW, 1000);
      write_reg(REG_SETTLE, 255);
      stride_run(320, 30, 5);
      drain();

      // Long receiver hold-off while the sender keeps offering beats.
      hold_req = 1;
      stride_run(20, 40, 3);
      drain();

      write_reg(REG_THRESHOLD, 180);
      write_reg(REG_RELEASE, 141);
      write_reg(REG_ALPHA, 655);
      write_reg(REG_MIN_STEP, 200);
      write_reg(REG_WINDOW, 10000);
      write_reg(REG_STALE, 3000);
      write_reg(REG_SETTLE, 3);
      send_beat(CMD_CLEAR, 0, 0, 0, 0);
      clock_ms = 0;
      for (int i = 0; i < 300; i++) begin
         if ($urandom_range(0, 4) == 0) random_beat();
         else stride_run(1 + $urandom_range(0, 4), 60 + $urandom_range(0, 80), 5);
         if (i == 150) drain();
      end
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d counted steps and %0d beats with nonzero cadence",
               board.steps_seen, board.nonzero_cad);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("impact_step_cadence_meter regression: pass");
      else
         $display("impact_step_cadence_meter regression: fail");
      $finish;
   end
endmodule

@@ sim.f @@
src/iscm_pkg.sv
src/iscm_if.sv
src/iscm_isqrt.sv
src/iscm_div.sv
src/impact_step_cadence_meter.sv
sim/impact_step_cadence_meter_tb.sv
